[rtl/rkns_pkg.sv]
// rkns_pkg: word types and fixed widths for the rotating k-of-n node selector
// used by rkns_keep and rotating_k_of_n_node_selector_core; no dependencies
package rkns_pkg;

	localparam int NODE_W = 64;
	localparam int CNT_W  = 7;
	localparam int PTR_W  = 6;
	localparam int GRP_W  = 8;
	localparam int GRP_N  = NODE_W / GRP_W;
	localparam int GCNT_W = 4;

	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

	typedef struct packed {
		logic [NODE_W-1:0] available_mask;
		logic [CNT_W-1:0]  wanted;
	} in_word_t;

	typedef struct packed {
		logic [NODE_W-1:0] selected_mask;
		logic [CNT_W-1:0]  selected_count;
	} out_word_t;

endpackage

[rtl/rotating_k_of_n_node_selector_core.sv]
// rotating_k_of_n_node_selector_core: top level of the rotating k-of-n node
// selector; depends on rkns_pkg and rkns_keep
//
//  channel | direction | handshake              | word
//  in      | input     | in_valid / in_stall    | in_word (available_mask, wanted)
//  out     | output    | out_valid / out_stall  | out_word (selected_mask, selected_count)
//  cfg     | input     | cfg_we                 | cfg_wdata (node_count)
//
// one word per cycle when the output is not stalled; the mask is rotated by the
// start pointer into an input register, then ranked and rotated back into the
// output register. the pointer advances at each accepted word.
// reset clears both stages, the pointer to zero and node_count to 64.
// a stall on the output holds both stages; the input is stalled only when
// the input register is full and cannot move on.
module rotating_k_of_n_node_selector_core
	import rkns_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_word,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_word,
	input  logic       cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam logic [NODE_W-1:0] NODE_MASK = (MAX_NODES >= NODE_W) ?
		{NODE_W{1'b1}} : ((NODE_W'(1) << MAX_NODES) - NODE_W'(1));
	localparam logic [CNT_W-1:0] MAX_NODES_C = CNT_W'(MAX_NODES);

	logic [CNT_W-1:0]    node_count_q;
	logic [PTR_W-1:0]    ptr_q;
	logic                valid_s1;
	logic [NODE_W-1:0]   rot_s1;
	logic [CNT_W-1:0]    want_s1;
	logic [PTR_W-1:0]    ptr_s1;
	logic                out_valid_q;
	out_word_t           out_word_q;

	logic                adv1, adv2, in_acc;
	logic [CNT_W-1:0]    ptr_inc;
	logic [NODE_W-1:0]   avail;
	logic [2*NODE_W-1:0] rot_in_wide;
	logic [NODE_W-1:0]   kept;
	logic [CNT_W-1:0]    total;
	logic [2*NODE_W-1:0] rot_out_wide;
	out_word_t           res;

	assign adv2     = !out_valid_q || !out_stall;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;
	assign in_acc   = in_valid && adv1;

	assign ptr_inc = {1'b0, ptr_q} + CNT_W'(1);

	// rotate right by the pointer: lower group lands on top, above the upper group
	assign avail       = in_word.available_mask & NODE_MASK;
	assign rot_in_wide = {avail, avail} >> ptr_q;

	rkns_keep u_keep (
		.bits  (rot_s1),
		.limit (want_s1),
		.kept  (kept),
		.total (total)
	);

	assign rot_out_wide       = {kept, kept} << ptr_s1;
	assign res.selected_mask  = rot_out_wide[2*NODE_W-1:NODE_W];
	assign res.selected_count = (want_s1 < total) ? want_s1 : total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (ptr_inc >= node_count_q || ptr_inc >= MAX_NODES_C) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_inc[PTR_W-1:0];
				end
			end
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rot_s1  <= rot_in_wide[NODE_W-1:0];
			want_s1 <= in_word.wanted;
			ptr_s1  <= ptr_q;
		end
		if (adv2 && valid_s1) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

[rtl/rkns_keep.sv]
// rkns_keep: keeps the highest set bits of a 64-bit vector up to a limit and
// returns the total number of set bits; depends on rkns_pkg
module rkns_keep
	import rkns_pkg::*;
(
	input  logic [NODE_W-1:0] bits,
	input  logic [CNT_W-1:0]  limit,
	output logic [NODE_W-1:0] kept,
	output logic [CNT_W-1:0]  total
);

	logic [GCNT_W-1:0] grp_cnt [GRP_N];
	logic [CNT_W-1:0]  grp_above [GRP_N];

	// per-group population counts
	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			grp_cnt[g] = GCNT_W'($countones(bits[g*GRP_W +: GRP_W]));
		end
	end

	// ones in all groups above each group
	always_comb begin
		grp_above[GRP_N-1] = '0;
		for (int g = GRP_N - 2; g >= 0; g--) begin
			grp_above[g] = grp_above[g+1] + CNT_W'(grp_cnt[g+1]);
		end
		total = grp_above[0] + CNT_W'(grp_cnt[0]);
	end

	// rank of each bit is the ones above it; keep while rank is under the limit
	always_comb begin
		logic [GRP_W-1:0] grp;
		logic [GRP_W-1:0] upper;
		logic [CNT_W-1:0] rank;
		for (int g = 0; g < GRP_N; g++) begin
			grp = bits[g*GRP_W +: GRP_W];
			for (int j = 0; j < GRP_W; j++) begin
				upper = grp & GRP_W'({GRP_W{1'b1}} << (j + 1));
				rank  = grp_above[g] + CNT_W'($countones(upper));
				kept[g*GRP_W + j] = grp[j] && (rank < limit);
			end
		end
	end

endmodule

[bench/rkns_selection_checker.sv]
// rkns_selection_checker: watches the request, result and node_count ports of
// the rotating k-of-n node selector, predicts each selection and compares it
// depends on rkns_pkg
module rkns_selection_checker
	import rkns_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_word_t         in_word,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_word_t        out_word,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               outstanding,
	output int               checked
);

	logic [CNT_W-1:0] node_count;
	logic [PTR_W-1:0] start_ptr;
	out_word_t        expected_picks[$];
	int               fails;
	int               compared;

	assign fail_count = fails;
	assign checked    = compared;

	// keeps the k highest set bits of x
	function automatic logic [NODE_W-1:0] keep_top(logic [NODE_W-1:0] x, int k);
		logic [NODE_W-1:0] kept;
		int n;
		kept = '0;
		n = 0;
		for (int i = NODE_W - 1; i >= 0; i--) begin
			if (x[i] && n < k) begin
				kept[i] = 1'b1;
				n++;
			end
		end
		return kept;
	endfunction

	function automatic out_word_t pick_nodes(in_word_t w, logic [PTR_W-1:0] p);
		logic [NODE_W-1:0] below;
		logic [NODE_W-1:0] lower;
		logic [NODE_W-1:0] upper;
		int nl;
		int want;
		out_word_t pick;
		below = (64'd1 << p) - 64'd1;
		lower = w.available_mask & below;
		upper = w.available_mask & ~below;
		nl = $countones(lower);
		want = int'(w.wanted);
		if (want <= nl) begin
			pick.selected_mask  = keep_top(lower, want);
			pick.selected_count = CNT_W'(want);
		end else begin
			pick.selected_mask  = lower | keep_top(upper, want - nl);
			pick.selected_count = CNT_W'($countones(pick.selected_mask));
		end
		return pick;
	endfunction

	function automatic logic [PTR_W-1:0] advance_ptr(logic [PTR_W-1:0] p,
			logic [CNT_W-1:0] count);
		int n;
		n = int'(p) + 1;
		if (n >= int'(count) || n >= NODE_W)
			return '0;
		return PTR_W'(n);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want_word;
		if (!arst_n) begin
			node_count  <= NODE_COUNT_RST;
			start_ptr   <= '0;
			outstanding <= 0;
			expected_picks.delete();
			fails    = 0;
			compared = 0;
		end else begin
			if (cfg_we)
				node_count <= cfg_wdata;
			if (in_valid && !in_stall) begin
				expected_picks.push_back(pick_nodes(in_word, start_ptr));
				start_ptr <= advance_ptr(start_ptr, node_count);
			end
			if (out_valid && !out_stall) begin
				if (expected_picks.size() == 0) begin
					if (fails < 10)
						$display("unexpected result word: mask %h count %0d",
							out_word.selected_mask, out_word.selected_count);
					fails++;
				end else begin
					want_word = expected_picks.pop_front();
					compared++;
					if (out_word.selected_mask !== want_word.selected_mask ||
							out_word.selected_count !== want_word.selected_count) begin
						if (fails < 10)
							$display("word %0d: mask exp %h got %h, count exp %0d got %0d",
								compared, want_word.selected_mask, out_word.selected_mask,
								want_word.selected_count, out_word.selected_count);
						fails++;
					end
				end
			end
			outstanding <= expected_picks.size();
		end
	end

endmodule

[bench/rotating_k_of_n_node_selector_core_tb.sv]
// rotating_k_of_n_node_selector_core_tb: drives requests and node_count writes
// into the selector with random gaps and stalls and gives the verdict
// depends on rkns_pkg, rotating_k_of_n_node_selector_core and rkns_selection_checker
module rotating_k_of_n_node_selector_core_tb;
	import rkns_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_word_t         in_word   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_word_t        out_word;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	int fail_count;
	int outstanding;
	int checked;
	int quiet_cycles = 0;
	int sent = 0;
	int writes = 0;
	bit calm = 1'b0;

	always #5 clk = ~clk;

	rotating_k_of_n_node_selector_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rkns_selection_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always @(posedge clk) begin
		out_stall <= !calm && $urandom_range(99) < 7;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("rotating_k_of_n_node_selector_core: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_request(logic [NODE_W-1:0] mask, int want);
		in_word_t w;
		w.available_mask = mask;
		w.wanted = CNT_W'(want);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic write_node_count(int value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		writes++;
	endtask

	function automatic logic [NODE_W-1:0] random_mask();
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1: return a & b & {$urandom, $urandom};
			2: return a | b;
			3: return '1;
			4: return '0;
			5: return 64'd1 << $urandom_range(63);
			6: return ~(64'd1 << $urandom_range(63));
			default: return a;
		endcase
	endfunction

	function automatic int random_wanted(logic [NODE_W-1:0] mask);
		int c;
		c = $countones(mask) + $urandom_range(4) - 2;
		case ($urandom_range(7))
			0: return 0;
			1: return NODE_W;
			2: return $urandom_range(8);
			3, 4: return (c < 0) ? 0 : (c > NODE_W) ? NODE_W : c;
			default: return $urandom_range(NODE_W);
		endcase
	endfunction

	task automatic send_random(int n);
		logic [NODE_W-1:0] m;
		repeat (n) begin
			m = random_mask();
			send_request(m, random_wanted(m));
		end
	endtask

	initial begin
		int phase_counts[9];
		phase_counts = '{64, 2, 33, 0, 127, 1, 65, 17, 64};
		phase_counts[7] = $urandom_range(1, 64);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pointer at zero, full node range
		send_request('1, 64);
		send_request('1, 0);
		send_request('0, 64);
		send_request(64'h8000_0000_0000_0000, 1);
		send_request(64'h0000_0000_0000_0001, 1);
		send_request(64'h5555_5555_5555_5555, 3);
		send_request(64'hAAAA_AAAA_AAAA_AAAA, 32);
		send_request(64'h0000_0000_0000_000F, 10);
		send_request('1, 1);
		send_request('1, 5);
		send_request(64'h0000_0000_0000_00FF, 12);
		send_request(64'hFFFF_0000_0000_0000, 40);
		send_request('1, 63);
		write_node_count(1);
		send_request('1, 64);
		send_request(64'hF0F0_F0F0_F0F0_F0F0, 7);
		write_node_count(0);
		send_request(64'h0F0F_0F0F_0F0F_0F0F, 20);
		send_request('1, 0);
		write_node_count(127);
		send_request(64'h8000_0000_0000_0001, 2);
		write_node_count(64);
		send_random(40);
		// pointer left above the new node_count
		write_node_count(5);
		send_request('1, 20);
		send_request('0, 0);

		for (int i = 0; i < 9; i++) begin
			write_node_count(phase_counts[i]);
			calm = (i == 4);
			send_random(120);
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		$display("%0d requests over %0d node_count writes, %0d selections compared",
			sent, writes, checked);
		if (fail_count == 0)
			$display("rotating_k_of_n_node_selector_core: match");
		else
			$display("rotating_k_of_n_node_selector_core: mismatch");
		$finish;
	end

endmodule
